FILE: rtl/core/skl_pkg.sv
`default_nettype none

package skl_pkg;

    // Table geometry
    localparam int CAPACITY  = 1024;
    localparam int REF_WIDTH = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Lookup reduction: cells are ORed in groups, then the groups are ORed
    localparam int GROUP     = 32;
    localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;
    localparam int PAD_CELLS = NGROUPS * GROUP;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [REF_WIDTH-1:0] nref_t;
    typedef logic [CNT_W-1:0]     count_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        key_t        key;
        logic [15:0] name_ref;
    } skl_in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] found_ref;
    } skl_out_t;

    // What one cell shows its right-hand neighbour
    typedef struct packed {
        logic  gt;     // empty or holding a key above the broadcast key
        logic  eq;     // occupied and holding the broadcast key
        key_t  key;
        nref_t nref;
    } skl_link_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_key_table_lookup_unit.sv
`default_nettype none

// Sorted key table of CAPACITY entries (32-bit key, name reference), held in a
// row of cells in ascending key order; equal keys keep insertion order, so a
// lookup answers with the earliest inserted entry of its key. Every input
// transaction gives one result transaction. For an insert (or a table-full
// report) all cells compare the key in the accepting cycle, the cells past the
// insertion point shift right by one, and the result is registered at that edge.
// A lookup runs in order: the cells compare and register their hit, then a
// registered OR over groups of GROUP cells, then an OR over the groups into the
// output register once it is free. The input is taken only when no lookup is in
// flight and the output register is empty or being drained, so inserts go at one
// item per cycle, and a lookup finishes before the next item is taken. No clearing
// pass is needed after reset; the fill count marks which cells hold entries.

module sorted_key_table_lookup_unit import skl_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire skl_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output skl_out_t     m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_FINAL
    } state_t;

    state_t   state_reg, state_next;
    count_t   count_reg, count_next;
    logic     m_valid_reg, m_valid_next;
    skl_out_t m_data_reg, m_data_next;

    logic  accept;
    logic  full;
    logic  ins_en;
    logic  look_en;
    logic  out_free;
    nref_t new_ref;

    skl_link_t links [CAPACITY];
    logic      cell_hit [PAD_CELLS];
    nref_t     cell_ref [PAD_CELLS];

    logic  group_hit_reg  [NGROUPS];
    nref_t group_ref_reg  [NGROUPS];
    logic  group_hit_next [NGROUPS];
    nref_t group_ref_next [NGROUPS];

    logic  total_hit;
    nref_t total_ref;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == count_t'(CAPACITY));
    assign ins_en   = accept && (s_data.kind == KIND_INSERT) && !full;
    assign look_en  = accept && (s_data.kind == KIND_LOOKUP);
    assign new_ref  = s_data.name_ref[REF_WIDTH-1:0];

    // Row of cells, each fed by its left neighbour
    genvar i;
    generate
        for (i = 0; i < PAD_CELLS; i++) begin : g_cell
            if (i < CAPACITY) begin : g_real
                skl_link_t prev_link;
                logic      occ;

                assign occ = (count_reg > count_t'(i));
                if (i == 0) begin : g_head
                    assign prev_link = '0;
                end else begin : g_body
                    assign prev_link = links[i-1];
                end

                skl_cell u_cell (
                    .aclk     (aclk),
                    .occupied (occ),
                    .ins_en   (ins_en),
                    .look_en  (look_en),
                    .new_key  (s_data.key),
                    .new_ref  (new_ref),
                    .prev     (prev_link),
                    .link     (links[i]),
                    .hit      (cell_hit[i]),
                    .hit_ref  (cell_ref[i])
                );
            end else begin : g_pad
                assign cell_hit[i] = 1'b0;
                assign cell_ref[i] = '0;
            end
        end
    endgenerate

    // First reduction level: OR the cells of each group
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            group_hit_next[g] = 1'b0;
            group_ref_next[g] = '0;
            for (int c = 0; c < GROUP; c++) begin
                group_hit_next[g] = group_hit_next[g] | cell_hit[g*GROUP + c];
                group_ref_next[g] = group_ref_next[g] | cell_ref[g*GROUP + c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_GROUP) begin
            for (int g = 0; g < NGROUPS; g++) begin
                group_hit_reg[g] <= group_hit_next[g];
                group_ref_reg[g] <= group_ref_next[g];
            end
        end
    end

    // Second reduction level: OR the groups
    always_comb begin
        total_hit = 1'b0;
        total_ref = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            total_hit = total_hit | group_hit_reg[g];
            total_ref = total_ref | group_ref_reg[g];
        end
    end

    // Sequencer, fill count and output register
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.kind == KIND_LOOKUP) begin
                        state_next = S_GROUP;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next.found_ref = '0;
                        if (full) begin
                            m_data_next.status = ST_FULL;
                        end else begin
                            m_data_next.status = ST_STORED;
                            count_next = count_reg + count_t'(1);
                        end
                    end
                end
            end
            S_GROUP: begin
                state_next = S_FINAL;
            end
            S_FINAL: begin
                // Hold until the output register is free
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next.status    = total_hit ? ST_FOUND : ST_MISSING;
                    m_data_next.found_ref = 16'(total_ref);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> (count_reg == $past(count_reg) + count_t'(1)))
        else $error("stored insert did not advance fill count");

    a_full_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.kind == KIND_INSERT)) |=>
            (m_valid && ((m_data.status == ST_FULL) == $past(full))))
        else $error("insert result disagrees with table occupancy");

    a_ref_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_FOUND)) |-> (m_data.found_ref == '0))
        else $error("reference set on a non-found result");

    a_lookup_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        look_en |=> (state_reg == S_GROUP) ##1 (state_reg == S_FINAL))
        else $error("lookup sequence broken");

endmodule

`default_nettype wire

FILE: rtl/core/skl_cell.sv
`default_nettype none

module skl_cell import skl_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      occupied,
    input  wire logic      ins_en,
    input  wire logic      look_en,
    input  wire key_t      new_key,
    input  wire nref_t     new_ref,
    input  wire skl_link_t prev,
    output skl_link_t      link,
    output logic           hit,
    output nref_t          hit_ref
);

    key_t  key_reg;
    nref_t nref_reg;
    logic  hit_reg;
    nref_t hit_ref_reg;
    logic  first;

    // Compare against the broadcast key
    always_comb begin
        link.gt   = !occupied || (key_reg > new_key);
        link.eq   = occupied && (key_reg == new_key);
        link.key  = key_reg;
        link.nref = nref_reg;
    end

    // Equal keys sit together, so only the leftmost equal cell answers
    assign first = link.eq && !prev.eq;

    // Shift right where the new entry lands ahead of us, take it at the boundary
    always_ff @(posedge aclk) begin
        if (ins_en && link.gt) begin
            if (prev.gt) begin
                key_reg  <= prev.key;
                nref_reg <= prev.nref;
            end else begin
                key_reg  <= new_key;
                nref_reg <= new_ref;
            end
        end
        if (look_en) begin
            hit_reg     <= first;
            hit_ref_reg <= first ? nref_reg : '0;
        end
    end

    assign hit     = hit_reg;
    assign hit_ref = hit_ref_reg;

endmodule

`default_nettype wire
